// ----- sv/ipv6tf_pkg.sv -----
// ----------------------------------------------------------------------------
// IPv6 text formatter package
// Shared types, constants and small helper functions for the formatter.
// ----------------------------------------------------------------------------
package ipv6tf_pkg;

    localparam int GROUP_COUNT = 8;
    localparam int GROUP_W     = 16;
    localparam int NIB_W       = 4;
    localparam int CHAR_W      = 7;
    localparam int MIN_RUN     = 2;

    // ASCII codes used by the character generator.
    localparam logic [CHAR_W-1:0] CHAR_COLON  = 7'h3A;
    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A_BIAS = 7'h57;  // 'a' minus ten

    // Eight address groups, index 0 is the most significant group.
    typedef logic [GROUP_COUNT-1:0][GROUP_W-1:0] groups_t;

    // One address request.
    typedef struct packed {
        logic [GROUP_W-1:0] group_0;
        logic [GROUP_W-1:0] group_1;
        logic [GROUP_W-1:0] group_2;
        logic [GROUP_W-1:0] group_3;
        logic [GROUP_W-1:0] group_4;
        logic [GROUP_W-1:0] group_5;
        logic [GROUP_W-1:0] group_6;
        logic [GROUP_W-1:0] group_7;
    } addr_t;

    // One output character.
    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              last_char;
    } char_t;

    // Zero run found by the scanner, as seen by the character generator.
    typedef struct packed {
        logic       compress;
        logic [2:0] run_first;
        logic [2:0] run_last;
    } run_info_t;

    // Index of the most significant nonzero nibble, or zero for a zero group.
    function automatic logic [1:0] top_nibble(input logic [GROUP_W-1:0] g);
        logic [1:0] idx;
        if (g[15:12] != 4'h0)
        begin
            idx = 2'd3;
        end
        else if (g[11:8] != 4'h0)
        begin
            idx = 2'd2;
        end
        else if (g[7:4] != 4'h0)
        begin
            idx = 2'd1;
        end
        else
        begin
            idx = 2'd0;
        end
        return idx;
    endfunction

    // Lowercase hex digit for one nibble.
    function automatic logic [CHAR_W-1:0] hex_char(input logic [NIB_W-1:0] nib);
        logic [CHAR_W-1:0] ch;
        if (nib < 4'd10)
        begin
            ch = CHAR_ZERO + {3'b000, nib};
        end
        else
        begin
            ch = CHAR_A_BIAS + {3'b000, nib};
        end
        return ch;
    endfunction

endpackage

// ----- sv/ipv6_text_formatter_core.sv -----
// ----------------------------------------------------------------------------
// IPv6 text formatter core
// Turns one IPv6 address into its compressed lowercase text form, one
// ASCII character per result strobe.
// ----------------------------------------------------------------------------
// A new request is taken only while busy is low, so requests are handled one at a time.
// Each address gives 2..39 characters; the zero run scan takes one group per
// cycle, and the generator emits one character per cycle.
// Characters leave at one per cycle and the receiver cannot stall them.
// Reset is asynchronous, active low, and clears the sequencers and strobe.
// ----------------------------------------------------------------------------
module ipv6_text_formatter_core
    import ipv6tf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  addr_t addr,
    output logic  result_valid,
    output char_t result
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0] state_reg, state_next;
    groups_t    groups_reg, groups_next;

    logic      accept;
    logic      scan_done;
    logic      emit_done;
    logic      emit_go;
    run_info_t run_info;

    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && !busy;
    assign emit_go = (state_reg == S_SCAN) && scan_done;

    // Capture the request; group 0 is the most significant.
    always_comb
    begin
        groups_next = groups_reg;
        if (accept)
        begin
            groups_next[0] = addr.group_0;
            groups_next[1] = addr.group_1;
            groups_next[2] = addr.group_2;
            groups_next[3] = addr.group_3;
            groups_next[4] = addr.group_4;
            groups_next[5] = addr.group_5;
            groups_next[6] = addr.group_6;
            groups_next[7] = addr.group_7;
        end
    end

    // Top sequencer: scan for the zero run, then emit characters.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        groups_reg <= groups_next;
    end

    ipv6tf_run_scan u_run_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (accept),
        .groups   (groups_reg),
        .done     (scan_done),
        .run_info (run_info)
    );

    ipv6tf_char_gen u_char_gen (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (emit_go),
        .groups     (groups_reg),
        .run_info   (run_info),
        .done       (emit_done),
        .char_valid (result_valid),
        .char_out   (result)
    );

`ifndef SYNTHESIS
    // A taken request always leaves the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("request taken but block not busy");

    // The last character is never followed directly by another one.
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last_char) |=> !result_valid)
        else $error("character strobe right after last character");

    // Characters only come out of the emit phase.
    a_strobe_phase: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ($past(state_reg) == S_EMIT))
        else $error("character strobe outside emit phase");

    // The scanner finishes only while the sequencer waits for it.
    a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
        scan_done |-> (state_reg == S_SCAN))
        else $error("scan finished outside scan phase");
`endif

endmodule

// ----- sv/ipv6tf_run_scan.sv -----
// ----------------------------------------------------------------------------
// IPv6 text formatter zero run scanner
// Walks the eight groups one per cycle with a shared length compare and
// keeps the first longest run of zero groups.
// ----------------------------------------------------------------------------
module ipv6tf_run_scan
    import ipv6tf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      go,
    input  groups_t   groups,
    output logic      done,
    output run_info_t run_info
);

    logic       active_reg,     active_next;
    logic       done_reg,       done_next;
    logic [2:0] idx_reg,        idx_next;
    logic [2:0] cur_start_reg,  cur_start_next;
    logic [3:0] cur_len_reg,    cur_len_next;
    logic [2:0] best_start_reg, best_start_next;
    logic [3:0] best_len_reg,   best_len_next;

    logic [3:0] run_end_sum;

    // One group per cycle: extend the current run and compare it to the best.
    always_comb
    begin
        active_next     = active_reg;
        done_next       = 1'b0;
        idx_next        = idx_reg;
        cur_start_next  = cur_start_reg;
        cur_len_next    = cur_len_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        if (go)
        begin
            active_next     = 1'b1;
            idx_next        = 3'd0;
            cur_start_next  = 3'd0;
            cur_len_next    = 4'd0;
            best_start_next = 3'd0;
            best_len_next   = 4'd0;
        end
        else if (active_reg)
        begin
            if (groups[idx_reg] == '0)
            begin
                if (cur_len_reg == 4'd0)
                begin
                    cur_start_next = idx_reg;
                end
                cur_len_next = cur_len_reg + 4'd1;
                if (cur_len_next > best_len_reg)
                begin
                    best_len_next   = cur_len_next;
                    best_start_next = cur_start_next;
                end
            end
            else
            begin
                cur_len_next = 4'd0;
            end
            idx_next = idx_reg + 3'd1;
            if (idx_reg == 3'(GROUP_COUNT - 1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        cur_start_reg  <= cur_start_next;
        cur_len_reg    <= cur_len_next;
        best_start_reg <= best_start_next;
        best_len_reg   <= best_len_next;
    end

    // The run end is summed at four bits, so a full-length run starting at zero ends at group seven without wrapping.
    assign run_end_sum        = {1'b0, best_start_reg} + best_len_reg - 4'd1;
    assign run_info.compress  = (best_len_reg >= 4'(MIN_RUN));
    assign run_info.run_first = best_start_reg;
    assign run_info.run_last  = run_end_sum[2:0];
    assign done               = done_reg;

endmodule

// ----- sv/ipv6tf_char_gen.sv -----
// ----------------------------------------------------------------------------
// IPv6 text formatter character generator
// Small sequencer that emits one ASCII character per cycle: hex digits
// without leading zeros, colons, and the double colon for the zero run.
// ----------------------------------------------------------------------------
module ipv6tf_char_gen
    import ipv6tf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      go,
    input  groups_t   groups,
    input  run_info_t run_info,
    output logic      done,
    output logic      char_valid,
    output char_t     char_out
);

    localparam logic [2:0] P_IDLE  = 3'd0;
    localparam logic [2:0] P_LEAD  = 3'd1;
    localparam logic [2:0] P_DIGIT = 3'd2;
    localparam logic [2:0] P_COLON = 3'd3;
    localparam logic [2:0] P_RUN   = 3'd4;

    logic [2:0] phase_reg, phase_next;
    logic [2:0] gi_reg,    gi_next;
    logic [1:0] ni_reg,    ni_next;
    logic       valid_reg, valid_next;
    char_t      char_reg,  char_next;

    logic [2:0]         enter_grp;
    logic               enter_en;
    logic [GROUP_W-1:0] cur_grp;
    logic [NIB_W-1:0]   cur_nib;
    logic               done_int;

    assign cur_grp = groups[gi_reg];
    assign cur_nib = cur_grp[{ni_reg, 2'b00} +: NIB_W];

    // Sequencer: pick the character for this cycle and the next position.
    always_comb
    begin
        phase_next = phase_reg;
        gi_next    = gi_reg;
        ni_next    = ni_reg;
        valid_next = 1'b0;
        char_next  = char_reg;
        enter_en   = 1'b0;
        enter_grp  = 3'd0;
        done_int   = 1'b0;
        case (phase_reg)
            P_IDLE:
            begin
                if (go)
                begin
                    if (run_info.compress && run_info.run_first == 3'd0)
                    begin
                        phase_next = P_LEAD;
                    end
                    else
                    begin
                        enter_en  = 1'b1;
                        enter_grp = 3'd0;
                    end
                end
            end
            P_LEAD:
            begin
                valid_next          = 1'b1;
                char_next.text_char = CHAR_COLON;
                char_next.last_char = 1'b0;
                enter_en            = 1'b1;
                enter_grp           = 3'd0;
            end
            P_RUN:
            begin
                valid_next          = 1'b1;
                char_next.text_char = CHAR_COLON;
                if (run_info.run_last == 3'(GROUP_COUNT - 1))
                begin
                    char_next.last_char = 1'b1;
                    phase_next          = P_IDLE;
                    done_int            = 1'b1;
                end
                else
                begin
                    char_next.last_char = 1'b0;
                    enter_en            = 1'b1;
                    enter_grp           = run_info.run_last + 3'd1;
                end
            end
            P_DIGIT:
            begin
                valid_next          = 1'b1;
                char_next.text_char = hex_char(cur_nib);
                char_next.last_char = 1'b0;
                if (ni_reg == 2'd0)
                begin
                    if (gi_reg == 3'(GROUP_COUNT - 1))
                    begin
                        char_next.last_char = 1'b1;
                        phase_next          = P_IDLE;
                        done_int            = 1'b1;
                    end
                    else
                    begin
                        phase_next = P_COLON;
                    end
                end
                else
                begin
                    ni_next = ni_reg - 2'd1;
                end
            end
            P_COLON:
            begin
                valid_next          = 1'b1;
                char_next.text_char = CHAR_COLON;
                char_next.last_char = 1'b0;
                enter_en            = 1'b1;
                enter_grp           = gi_reg + 3'd1;
            end
            default:
            begin
                phase_next = P_IDLE;
            end
        endcase

        // Entering a group: the run start becomes the double colon, any other
        // group starts at its most significant nonzero nibble.
        if (enter_en)
        begin
            gi_next = enter_grp;
            if (run_info.compress && enter_grp == run_info.run_first)
            begin
                phase_next = P_RUN;
            end
            else
            begin
                phase_next = P_DIGIT;
                ni_next    = top_nibble(groups[enter_grp]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gi_reg   <= gi_next;
        ni_reg   <= ni_next;
        char_reg <= char_next;
    end

    assign done       = done_int;
    assign char_valid = valid_reg;
    assign char_out   = char_reg;

endmodule
